@@ hw/rtl/hrwl_pkg.sv @@
// ----------------------------------------------------------------------------
// hrwl_pkg
// Shared types, constants and helpers of the hex record word loader.
// ----------------------------------------------------------------------------
package hrwl_pkg;

    // Highest word address that a write may target is 2^ADDR_WIDTH - 1.
    localparam int ADDR_WIDTH = 16;
    // The record address is 16 bits wide, so the counter always holds at
    // least that, plus one bit to see the step past the limit.
    localparam int CNT_W = ((ADDR_WIDTH > 16) ? ADDR_WIDTH : 16) + 1;
    localparam logic [CNT_W-1:0] ADDR_LIMIT = CNT_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [7:0] REC_DATA  = 8'h00;
    localparam logic [7:0] REC_EOF   = 8'h01;
    localparam logic [7:0] REC_SEGMT = 8'h02;

    // Number of output queue entries.
    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        EV_WRITE    = 3'd0,
        EV_SYNTAX   = 3'd1,
        EV_CHECKSUM = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_BADLEN   = 3'd4,
        EV_UNKNOWN  = 3'd5,
        EV_END      = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        PH_COLON  = 3'b001,
        PH_RECORD = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    typedef struct packed {
        event_t      ev;
        logic [15:0] addr;
        logic [15:0] data;
        logic        last;
    } result_t;

    // Results that one character adds to the output queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

    function automatic result_t make_result(input event_t ev, input logic [15:0] addr,
                                            input logic [15:0] data);
        result_t r;
        r.ev   = ev;
        r.addr = addr;
        r.data = data;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

@@ hw/rtl/hrwl_channels.sv @@
// ----------------------------------------------------------------------------
// hrwl channels
// Valid/ready channels for the character stream and for the result stream.
// ----------------------------------------------------------------------------
interface char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [15:0] word_addr;
    logic [15:0] word_data;
    logic        last;

    modport source (output valid, output event_res, output word_addr, output word_data,
                    output last, input ready);
    modport sink   (input valid, input event_res, input word_addr, input word_data,
                    input last, output ready);
endinterface

@@ hw/rtl/hrwl_parser.sv @@
// ----------------------------------------------------------------------------
// hrwl_parser
// Input register and record state; decodes one character a cycle, while the
// queue has room, into up to two results for the output queue.
// ----------------------------------------------------------------------------
module hrwl_parser
    import hrwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       room,
    output push_t      push
);

    logic             in_valid_reg;
    logic [7:0]       char_reg;
    phase_t           phase_reg, phase_next;
    logic             nibble_pending_reg, nibble_pending_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic [8:0]       byte_index_reg, byte_index_next;
    logic [7:0]       record_length_reg, record_length_next;
    logic [7:0]       record_type_reg, record_type_next;
    logic [CNT_W-1:0] addr_counter_reg, addr_counter_next;
    logic [7:0]       byte_sum_reg, byte_sum_next;
    logic [7:0]       held_high_byte_reg, held_high_byte_next;
    logic             halted_reg, halted_next;

    logic             fire;
    logic [3:0]       nib;
    logic [7:0]       byte_val;
    logic [7:0]       sum_add;
    logic [CNT_W-1:0] addr_join;
    logic [1:0]       n;
    result_t          r0, r1;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;
    assign nib      = hex_value(char_reg);
    assign byte_val = {high_nibble_reg, nib};
    assign sum_add  = byte_sum_reg + byte_val;
    assign addr_join = addr_counter_reg | CNT_W'(byte_val);

    always_comb
    begin
        phase_next          = phase_reg;
        nibble_pending_next = nibble_pending_reg;
        high_nibble_next    = high_nibble_reg;
        byte_index_next     = byte_index_reg;
        record_length_next  = record_length_reg;
        record_type_next    = record_type_reg;
        addr_counter_next   = addr_counter_reg;
        byte_sum_next       = byte_sum_reg;
        held_high_byte_next = held_high_byte_reg;
        halted_next         = halted_reg;
        n  = 2'd0;
        r0 = make_result(EV_WRITE, 16'd0, 16'd0);
        r1 = make_result(EV_END, 16'd0, 16'd0);

        if (fire && !halted_reg) begin
            if (char_reg == CHAR_NEWLINE) begin
                if (phase_reg != PH_SKIP) begin
                    n  = 2'd1;
                    r0 = make_result(EV_SYNTAX, 16'd0, 16'd0);
                end
                phase_next          = PH_COLON;
                nibble_pending_next = 1'b0;
            end
            else begin
                case (phase_reg)
                    PH_COLON:
                    begin
                        if (char_reg == CHAR_COLON) begin
                            phase_next          = PH_RECORD;
                            byte_index_next     = 9'd0;
                            byte_sum_next       = 8'd0;
                            nibble_pending_next = 1'b0;
                        end
                        else begin
                            n          = 2'd1;
                            r0         = make_result(EV_SYNTAX, 16'd0, 16'd0);
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_RECORD:
                    begin
                        if (!nibble_pending_reg) begin
                            high_nibble_next    = nib;
                            nibble_pending_next = 1'b1;
                        end
                        else begin
                            nibble_pending_next = 1'b0;
                            byte_sum_next       = sum_add;
                            byte_index_next     = byte_index_reg + 9'd1;
                            if (byte_index_reg == 9'd0) begin
                                record_length_next = byte_val;
                            end
                            else if (byte_index_reg == 9'd1) begin
                                addr_counter_next = CNT_W'(byte_val) << 8;
                            end
                            else if (byte_index_reg == 9'd2) begin
                                addr_counter_next = addr_join;
                                if (addr_join > ADDR_LIMIT) begin
                                    n          = 2'd1;
                                    r0         = make_result(EV_OVERFLOW, 16'd0, 16'd0);
                                    phase_next = PH_SKIP;
                                end
                            end
                            else if (byte_index_reg == 9'd3) begin
                                record_type_next = byte_val;
                                if (byte_val != REC_SEGMT && record_length_reg[0]) begin
                                    n           = 2'd1;
                                    r0          = make_result(EV_BADLEN, 16'd0, 16'd0);
                                    halted_next = 1'b1;
                                end
                                else if (byte_val != REC_DATA && byte_val != REC_EOF) begin
                                    n  = 2'd1;
                                    r0 = make_result(EV_UNKNOWN, 16'd0, 16'd0);
                                end
                            end
                            else if (byte_index_reg < {1'b0, record_length_reg} + 9'd4) begin
                                if (record_type_reg == REC_DATA) begin
                                    // Data bytes pair up from the first one.
                                    if (!byte_index_reg[0]) begin
                                        held_high_byte_next = byte_val;
                                    end
                                    else if (addr_counter_reg > ADDR_LIMIT) begin
                                        n          = 2'd1;
                                        r0 = make_result(EV_OVERFLOW, 16'd0, 16'd0);
                                        phase_next = PH_SKIP;
                                    end
                                    else begin
                                        n  = 2'd1;
                                        r0 = make_result(EV_WRITE, addr_counter_reg[15:0],
                                                         {held_high_byte_reg, byte_val});
                                        addr_counter_next = addr_counter_reg + CNT_W'(1);
                                    end
                                end
                            end
                            else begin
                                // Checksum byte closes the record.
                                if (sum_add != 8'd0) begin
                                    n  = 2'd1;
                                    r0 = make_result(EV_CHECKSUM, 16'd0, 16'd0);
                                end
                                if (record_type_reg == REC_EOF) begin
                                    if (sum_add != 8'd0) begin
                                        n  = 2'd2;
                                        r1 = make_result(EV_END, 16'd0, 16'd0);
                                    end
                                    else begin
                                        n  = 2'd1;
                                        r0 = make_result(EV_END, 16'd0, 16'd0);
                                    end
                                    halted_next = 1'b1;
                                end
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        r0.last    = (n == 2'd1);
        r1.last    = 1'b1;
        push.count = n;
        push.r0    = r0;
        push.r1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg       <= 1'b0;
            phase_reg          <= PH_COLON;
            nibble_pending_reg <= 1'b0;
            high_nibble_reg    <= 4'd0;
            byte_index_reg     <= 9'd0;
            record_length_reg  <= 8'd0;
            record_type_reg    <= 8'd0;
            addr_counter_reg   <= '0;
            byte_sum_reg       <= 8'd0;
            held_high_byte_reg <= 8'd0;
            halted_reg         <= 1'b0;
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            phase_reg          <= phase_next;
            nibble_pending_reg <= nibble_pending_next;
            high_nibble_reg    <= high_nibble_next;
            byte_index_reg     <= byte_index_next;
            record_length_reg  <= record_length_next;
            record_type_reg    <= record_type_next;
            addr_counter_reg   <= addr_counter_next;
            byte_sum_reg       <= byte_sum_next;
            held_high_byte_reg <= held_high_byte_next;
            halted_reg         <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            char_reg <= char_in;
        end
    end

`ifndef SYNTHESIS
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> push.count == 2'd0)
        else $error("parser produced a result while halted");

    a_pair_is_eof: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.r0.ev == EV_CHECKSUM && push.r1.ev == EV_END
                               && halted_next)
        else $error("two results for one item that is not a failed end record");
`endif

endmodule

@@ hw/rtl/hrwl_out_queue.sv @@
// ----------------------------------------------------------------------------
// hrwl_out_queue
// Result queue: takes up to two results a cycle, gives one a cycle when ready.
// ----------------------------------------------------------------------------
module hrwl_out_queue
    import hrwl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int IDX_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    result_t           entries_reg [QDEPTH];
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              pop;
    logic [IDX_W-1:0]  tail_plus1;

    // Room for the worst case of one item, whatever is taken this cycle.
    assign room       = count_reg <= CNT_QW'(QDEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_res    = entries_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign tail_plus1 = tail_reg + IDX_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + IDX_W'(1) : head_reg;
        tail_next  = tail_reg + IDX_W'(push.count);
        count_next = count_reg + CNT_QW'(push.count) - CNT_QW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            entries_reg[tail_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            entries_reg[tail_plus1] <= push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CNT_QW'(QDEPTH - 2))
        else $error("result pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_QW'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/hex_record_word_loader.sv @@
// ----------------------------------------------------------------------------
// hex_record_word_loader
// Intel HEX text parser that turns data records into 16-bit word writes.
// ----------------------------------------------------------------------------
// The loader takes one character per cycle while the queue has room, and gives
// at most one result per cycle. A character goes through an input register and
// the record decoder, and its results are written into the output queue before
// they are valid on the result channel. Nearly every character gives zero or
// one result, so the stream runs at one item per cycle unless the queue or the
// result channel stalls it; only a failed checksum on an end record gives two
// results. Results wait in a four-entry queue, and the held character is
// decoded only while the queue has room for two more. After a bad length or end
// of data the loader halts: it keeps taking characters but gives no result
// until reset.
module hex_record_word_loader
    import hrwl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    char_if.sink     chars,
    result_if.source results
);

    push_t   push;
    logic    room;
    result_t out_res;

    hrwl_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chars.valid),
        .in_ready (chars.ready),
        .char_in  (chars.char_in),
        .room     (room),
        .push     (push)
    );

    hrwl_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_res   (out_res)
    );

    assign results.event_res = out_res.ev;
    assign results.word_addr = out_res.addr;
    assign results.word_data = out_res.data;
    assign results.last      = out_res.last;

endmodule
